// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the comment stripper.
// Every check is sampled on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define CCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that the antecedent implies the consequent in the same cycle.
`define CCS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ccs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Comment stripper package
// Character codes, context modes, result queue sizes and the result type.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int SPACE_RUN_MAX = 255;
  localparam int SPACE_LIMIT_INT = (SPACE_RUN_MAX < 255) ? SPACE_RUN_MAX : 255;
  localparam logic [7:0] SPACE_LIMIT = 8'(SPACE_LIMIT_INT);

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int RES_DEPTH = 4;
  localparam int PTR_W     = $clog2(RES_DEPTH);
  localparam int CNT_W     = $clog2(RES_DEPTH + 1);

  typedef enum logic [3:0] {
    M_CODE  = 4'd0,
    M_SLASH = 4'd1,
    M_BLOCK = 4'd2,
    M_BSTAR = 4'd3,
    M_LINE  = 4'd4,
    M_STR   = 4'd5,
    M_CHR   = 4'd6
  } mode_e;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [7:0] spaces_before;
    logic       last_of_run;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/c_comment_stripper_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// C comment stripper core
// Removes block and line comments from a byte stream of C source, keeping
// string and character literals intact and holding runs of spaces as counts.
// ----------------------------------------------------------------------------
// The core takes one source byte per cycle while in_stall_o is low. The context
// update and the one or two results of a byte are formed in the accepting cycle,
// and the results go into a four-entry result queue, so a result appears in the
// cycle after its byte is accepted at the earliest. The queue drains one result
// per cycle while out_stall_i is low; the two results of a byte (a held slash
// followed by a kept byte) leave it one after the other. The input stalls while
// fewer than two queue entries are free, so with an output that never stalls
// the core sustains one byte per cycle, slowed only by the two-result bytes.
`include "assert_macros.svh"

module c_comment_stripper_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] byte_in_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      byte_out_o,
  output logic [7:0]      spaces_before_o,
  output logic            last_of_run_o
);
  import ccs_pkg::*;

  mode_e            mode_q, mode_d;
  logic             bs_q, bs_d;
  logic [7:0]       held_q, held_d;
  logic             cont_q, cont_d;

  res_t             fifo_q [RES_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic             in_acc, out_acc;
  logic [1:0]       n_res;
  res_t             r0, r1;
  logic             do_code, put_c;
  logic [7:0]       b, quote;

  assign b       = byte_in_i;
  assign in_stall_o  = (cnt_q > CNT_W'(RES_DEPTH - 2));
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_acc = out_valid_o && !out_stall_i;
  assign {byte_out_o, spaces_before_o, last_of_run_o} = fifo_q[rd_q];

  always_comb begin
    mode_d  = mode_q;
    bs_d    = bs_q;
    held_d  = held_q;
    cont_d  = cont_q;
    n_res   = 2'd0;
    r0      = '0;
    r1      = '0;
    do_code = 1'b0;
    put_c   = 1'b0;
    quote   = (mode_q == M_STR) ? CH_DQUOTE : CH_SQUOTE;

    unique case (mode_q)
      M_CODE: begin
        do_code = 1'b1;
      end
      M_SLASH: begin
        if (b == CH_SLASH) begin
          mode_d = M_LINE;
          bs_d   = 1'b0;
        end else if (b == CH_STAR) begin
          mode_d = M_BLOCK;
        end else begin
          r0      = '{byte_out: CH_SLASH, spaces_before: held_d, last_of_run: 1'b1};
          n_res   = 2'd1;
          held_d  = '0;
          cont_d  = 1'b1;
          mode_d  = M_CODE;
          do_code = 1'b1;
        end
      end
      M_BLOCK, M_BSTAR: begin
        if (b == CH_NL) begin
          if (cont_q) begin
            r0    = '{byte_out: CH_NL, spaces_before: held_q, last_of_run: 1'b1};
            n_res = 2'd1;
          end
          held_d = '0;
          cont_d = 1'b0;
          mode_d = M_BLOCK;
        end else if (b == CH_STAR) begin
          mode_d = M_BSTAR;
        end else if (b == CH_SLASH && mode_q == M_BSTAR) begin
          mode_d = M_CODE;
        end else begin
          mode_d = M_BLOCK;
        end
      end
      M_LINE: begin
        if (b == CH_NL) begin
          if (cont_q) begin
            r0    = '{byte_out: CH_NL, spaces_before: held_q, last_of_run: 1'b1};
            n_res = 2'd1;
          end
          held_d = '0;
          cont_d = 1'b0;
          if (!bs_q) begin
            mode_d = M_CODE;
          end
          bs_d = 1'b0;
        end else begin
          bs_d = (b == CH_BSLASH);
        end
      end
      M_STR, M_CHR: begin
        if (b == CH_NL) begin
          if (cont_q) begin
            r0    = '{byte_out: CH_NL, spaces_before: held_q, last_of_run: 1'b1};
            n_res = 2'd1;
          end
          held_d = '0;
          cont_d = 1'b0;
          if (!bs_q) begin
            mode_d = M_CODE;
          end
          bs_d = 1'b0;
        end else begin
          r0     = '{byte_out: b, spaces_before: held_q, last_of_run: 1'b1};
          n_res  = 2'd1;
          held_d = '0;
          cont_d = 1'b1;
          if (bs_q) begin
            bs_d = 1'b0;
          end else if (b == CH_BSLASH) begin
            bs_d = 1'b1;
          end else if (b == quote) begin
            mode_d = M_CODE;
          end
        end
      end
      default: begin
        mode_d  = M_CODE;
        do_code = 1'b1;
      end
    endcase

    if (do_code) begin
      if (b == CH_SPACE) begin
        if (held_d < SPACE_LIMIT) begin
          held_d = held_d + 8'd1;
        end
      end else if (b == CH_SLASH) begin
        mode_d = M_SLASH;
      end else if (b == CH_DQUOTE) begin
        put_c  = 1'b1;
        mode_d = M_STR;
        bs_d   = 1'b0;
      end else if (b == CH_SQUOTE) begin
        put_c  = 1'b1;
        mode_d = M_CHR;
        bs_d   = 1'b0;
      end else if (b == CH_NL) begin
        put_c = cont_d;
      end else begin
        put_c = 1'b1;
      end

      if (put_c) begin
        if (n_res == 2'd0) begin
          r0    = '{byte_out: b, spaces_before: held_d, last_of_run: 1'b1};
          n_res = 2'd1;
        end else begin
          r0.last_of_run = 1'b0;
          r1    = '{byte_out: b, spaces_before: held_d, last_of_run: 1'b1};
          n_res = 2'd2;
        end
        held_d = '0;
        cont_d = 1'b1;
      end
      if (b == CH_NL) begin
        held_d = '0;
        cont_d = 1'b0;
      end
    end
  end

  always_comb begin
    wr_nx = wr_q + PTR_W'(1);
    wr_d  = in_acc ? (wr_q + PTR_W'(n_res)) : wr_q;
    rd_d  = out_acc ? (rd_q + PTR_W'(1)) : rd_q;
    cnt_d = cnt_q + (in_acc ? CNT_W'(n_res) : CNT_W'(0)) - CNT_W'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_CODE;
      bs_q   <= 1'b0;
      held_q <= '0;
      cont_q <= 1'b0;
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
    end else begin
      if (in_acc) begin
        mode_q <= mode_d;
        bs_q   <= bs_d;
        held_q <= held_d;
        cont_q <= cont_d;
      end
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && n_res != 2'd0) begin
      fifo_q[wr_q] <= r0;
    end
    if (in_acc && n_res == 2'd2) begin
      fifo_q[wr_nx] <= r1;
    end
  end

  `CCS_ASSERT(a_cnt_range, cnt_q <= CNT_W'(RES_DEPTH), "Result queue count exceeds its depth.")
  `CCS_ASSERT(a_held_limit, held_q <= SPACE_LIMIT, "Held space count exceeds its limit.")
  `CCS_ASSERT_IMP(a_ptr_track, cnt_q != CNT_W'(RES_DEPTH),
                  PTR_W'(wr_q - rd_q) == cnt_q[PTR_W-1:0],
                  "Queue pointers disagree with the queue count.")
  `CCS_ASSERT_IMP(a_pair_queued, out_acc && !last_of_run_o, cnt_q >= CNT_W'(2),
                  "First result of a pair left without its partner queued.")

endmodule
`default_nettype wire
